[rtl/tiv_pkg.sv]
// Package for the tagged identifier validator.
// Byte codes, code point ranges and shared types; no dependencies.

package tiv_pkg;

	localparam int unsigned CP_W = 21;
	localparam int unsigned NUM_RANGES = 30;

	localparam logic [7:0] CH_D      = 8'h64;
	localparam logic [7:0] CH_I      = 8'h69;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_US     = 8'h5F;
	localparam logic [7:0] CH_HYPHEN = 8'h2D;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_1      = 8'h31;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_LA     = 8'h61;
	localparam logic [7:0] CH_LZ     = 8'h7A;
	localparam logic [7:0] CH_UA     = 8'h41;
	localparam logic [7:0] CH_UZ     = 8'h5A;

	typedef struct packed {
		logic [CP_W-1:0] lo;
		logic [CP_W-1:0] hi;
	} cp_range_t;

	// control, format and separator code points, inclusive bounds
	localparam cp_range_t FORBID_RANGES [NUM_RANGES] = '{
		'{21'h00000, 21'h0001F}, '{21'h0007F, 21'h0009F},
		'{21'h000AD, 21'h000AD}, '{21'h00600, 21'h00605},
		'{21'h0061C, 21'h0061C}, '{21'h006DD, 21'h006DD},
		'{21'h0070F, 21'h0070F}, '{21'h008E2, 21'h008E2},
		'{21'h0180E, 21'h0180E}, '{21'h0200B, 21'h0200F},
		'{21'h0202A, 21'h0202E}, '{21'h02060, 21'h02064},
		'{21'h02066, 21'h0206F}, '{21'h0FEFF, 21'h0FEFF},
		'{21'h0FFF9, 21'h0FFFB}, '{21'h110BD, 21'h110BD},
		'{21'h110CD, 21'h110CD}, '{21'h13430, 21'h13438},
		'{21'h1BCA0, 21'h1BCA3}, '{21'h1D173, 21'h1D17A},
		'{21'hE0001, 21'hE0001}, '{21'hE0020, 21'hE007F},
		'{21'h00020, 21'h00020}, '{21'h000A0, 21'h000A0},
		'{21'h01680, 21'h01680}, '{21'h02000, 21'h0200A},
		'{21'h02028, 21'h02029}, '{21'h0202F, 21'h0202F},
		'{21'h0205F, 21'h0205F}, '{21'h03000, 21'h03000}
	};

	typedef struct packed {
		logic valid;
		logic match;
	} verdict_t;

endpackage

[rtl/tagged_id_utf8_validator.sv]
// Top level of the tagged identifier validator: input register, parser, result register.
// Depends on tiv_pkg and tiv_parser.
//
// Usage:
//  The slave channel carries one string byte per transaction (tdata) with
//  tlast on the final byte. For each string the master channel gives one
//  transaction, m_tdata[0] = 1 when the string has the form
//  d:_ (i:<decimal without leading zero> | n:<letters, digits, hyphens>) _ <tail>
//  where the tail is one or more UTF-8 code points with no control, format
//  or separator characters.
//  The verdict reaches m_tvalid through the input register, then the result
//  register, once the last byte has been taken.
//  Throughput: one byte per cycle unless a final byte is held; the parser
//  state updates per accepted byte; consecutive bytes and strings follow back to back.
//  Stall: only a final byte needs the result register; while a verdict
//  waits and m_tready is low, plain bytes keep flowing, and the next final
//  byte holds in the input register until the result is taken.
//  Reset: arst_n clears all valid flags and returns the parser to the
//  start of the prefix. After each final byte the parser restarts likewise.

module tagged_id_utf8_validator (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] byte_req
	input  logic       s_tlast,   // last
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata    // [0] match, [7:1] zero
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              last_s1;
	logic              adv;
	logic              out_valid_q;
	logic              out_match_q;
	tiv_pkg::verdict_t verdict;

	assign adv      = valid_s1 && (!last_s1 || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	tiv_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.byte_s1 (byte_s1),
		.last_s1 (last_s1),
		.verdict (verdict)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_match_q <= 1'b0;
		end else if (verdict.valid) begin
			out_valid_q <= 1'b1;
			out_match_q <= verdict.match;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_match_q};

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && last_s1 && out_valid_q && !m_tready))
		else $error("input stalled without a blocked result");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && last_s1) |=> m_tvalid)
		else $error("final byte did not produce a result");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(valid_s1 && last_s1))
		else $error("result without a final byte");

endmodule

[rtl/tiv_cp_class.sv]
// Code point classifier: flags control, format and separator code points.
// Depends on tiv_pkg.

module tiv_cp_class (
	input  logic [tiv_pkg::CP_W-1:0] cp,
	output logic                     forbidden
);

	logic [tiv_pkg::NUM_RANGES-1:0] hit;

	always_comb begin
		for (int unsigned i = 0; i < tiv_pkg::NUM_RANGES; i++) begin
			hit[i] = (cp >= tiv_pkg::FORBID_RANGES[i].lo) &&
				(cp <= tiv_pkg::FORBID_RANGES[i].hi);
		end
	end

	assign forbidden = |hit;

endmodule

[rtl/tiv_parser.sv]
// Pattern state machine and UTF-8 tail decoder, one byte per cycle while adv is high.
// Depends on tiv_pkg and tiv_cp_class.

module tiv_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic [7:0]        byte_s1,
	input  logic              last_s1,
	output tiv_pkg::verdict_t verdict
);

	typedef enum logic [3:0] {
		PH_D, PH_COLON1, PH_US1, PH_KIND, PH_ICOLON, PH_IFIRST,
		PH_IMORE, PH_NCOLON, PH_NFIRST, PH_NMORE, PH_TAIL
	} phase_t;

	phase_t                    phase_q, phase_n;
	logic                      rej_q, rej_n;
	logic [1:0]                pend_q, pend_n;
	logic [tiv_pkg::CP_W-1:0]  acc_q, acc_n;
	logic                      tail_q, tail_n;
	logic                      fin;
	logic [tiv_pkg::CP_W-1:0]  cp_fin;
	logic [tiv_pkg::CP_W-1:0]  acc_shift;
	logic                      forbidden;
	logic                      is_digit, is_name;

	assign is_digit = (byte_s1 >= tiv_pkg::CH_0) && (byte_s1 <= tiv_pkg::CH_9);
	assign is_name  = is_digit || (byte_s1 == tiv_pkg::CH_HYPHEN) ||
		((byte_s1 >= tiv_pkg::CH_LA) && (byte_s1 <= tiv_pkg::CH_LZ)) ||
		((byte_s1 >= tiv_pkg::CH_UA) && (byte_s1 <= tiv_pkg::CH_UZ));
	assign acc_shift = {acc_q[tiv_pkg::CP_W-7:0], byte_s1[5:0]};

	tiv_cp_class u_class (
		.cp        (cp_fin),
		.forbidden (forbidden)
	);

	// tail decode: find the completed code point, if any
	always_comb begin
		fin    = 1'b0;
		cp_fin = '0;
		acc_n  = acc_q;
		pend_n = pend_q;
		if (pend_q != 2'd0) begin
			acc_n  = acc_shift;
			pend_n = pend_q - 2'd1;
			fin    = (pend_q == 2'd1);
			cp_fin = acc_shift;
		end else if (!byte_s1[7]) begin
			fin    = 1'b1;
			cp_fin = {13'd0, byte_s1};
		end else if (byte_s1[7:5] == 3'b110) begin
			acc_n  = {16'd0, byte_s1[4:0]};
			pend_n = 2'd1;
		end else if (byte_s1[7:4] == 4'b1110) begin
			acc_n  = {17'd0, byte_s1[3:0]};
			pend_n = 2'd2;
		end else if (byte_s1[7:3] == 5'b11110) begin
			acc_n  = {18'd0, byte_s1[2:0]};
			pend_n = 2'd3;
		end else begin
			fin = 1'b1;
		end
	end

	logic [1:0]               pend_t;
	logic [tiv_pkg::CP_W-1:0] acc_t;
	logic                     tail_t;

	always_comb begin
		phase_n = phase_q;
		rej_n   = rej_q;
		pend_t  = pend_q;
		acc_t   = acc_q;
		tail_t  = tail_q;
		if (!rej_q) begin
			case (phase_q)
				PH_D: begin
					if (byte_s1 == tiv_pkg::CH_D) phase_n = PH_COLON1;
					else rej_n = 1'b1;
				end
				PH_COLON1: begin
					if (byte_s1 == tiv_pkg::CH_COLON) phase_n = PH_US1;
					else rej_n = 1'b1;
				end
				PH_US1: begin
					if (byte_s1 == tiv_pkg::CH_US) phase_n = PH_KIND;
					else rej_n = 1'b1;
				end
				PH_KIND: begin
					if (byte_s1 == tiv_pkg::CH_I) phase_n = PH_ICOLON;
					else if (byte_s1 == tiv_pkg::CH_N) phase_n = PH_NCOLON;
					else rej_n = 1'b1;
				end
				PH_ICOLON: begin
					if (byte_s1 == tiv_pkg::CH_COLON) phase_n = PH_IFIRST;
					else rej_n = 1'b1;
				end
				PH_IFIRST: begin
					if (byte_s1 >= tiv_pkg::CH_1 && byte_s1 <= tiv_pkg::CH_9)
						phase_n = PH_IMORE;
					else rej_n = 1'b1;
				end
				PH_IMORE: begin
					if (byte_s1 == tiv_pkg::CH_US) phase_n = PH_TAIL;
					else if (!is_digit) rej_n = 1'b1;
				end
				PH_NCOLON: begin
					if (byte_s1 == tiv_pkg::CH_COLON) phase_n = PH_NFIRST;
					else rej_n = 1'b1;
				end
				PH_NFIRST: begin
					if (is_name) phase_n = PH_NMORE;
					else rej_n = 1'b1;
				end
				PH_NMORE: begin
					if (byte_s1 == tiv_pkg::CH_US) phase_n = PH_TAIL;
					else if (!is_name) rej_n = 1'b1;
				end
				PH_TAIL: begin
					pend_t = pend_n;
					acc_t  = acc_n;
					if (fin) begin
						if (forbidden) rej_n = 1'b1;
						else tail_t = 1'b1;
					end
				end
				default: begin
					rej_n = 1'b1;
				end
			endcase
		end
	end

	assign verdict.valid = adv && last_s1;
	assign verdict.match = !rej_n && (phase_n == PH_TAIL) && (pend_t == 2'd0) && tail_t;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_D;
			rej_q   <= 1'b0;
			pend_q  <= 2'd0;
			acc_q   <= '0;
			tail_q  <= 1'b0;
		end else if (adv) begin
			if (last_s1) begin
				phase_q <= PH_D;
				rej_q   <= 1'b0;
				pend_q  <= 2'd0;
				acc_q   <= '0;
				tail_q  <= 1'b0;
			end else begin
				phase_q <= phase_n;
				rej_q   <= rej_n;
				pend_q  <= pend_t;
				acc_q   <= acc_t;
				tail_q  <= tail_t;
			end
		end
	end

endmodule

[bench/tiv_checker.sv]
// Checker for the tagged identifier validator: follows both stream channels,
// parses each accepted byte and compares every verdict against the prediction.
// Depends on tiv_pkg for the byte codes.
`timescale 1ns / 100ps

module tiv_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	input  logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] byte_req
	input  logic       s_tlast,   // last
	input  logic       m_tvalid,
	input  logic       m_tready,
	input  logic [7:0] m_tdata,   // [0] match, [7:1] zero
	output int         fails,
	output int         verdicts_pending
);

	typedef enum logic [3:0] {
		P_D, P_COLON1, P_US1, P_KIND, P_ICOLON, P_IFIRST, P_IMORE,
		P_NCOLON, P_NFIRST, P_NMORE, P_TAIL
	} parse_phase_t;

	parse_phase_t phase;
	logic         rejected;
	logic [1:0]   cont_left;
	logic [20:0]  cp_acc;
	logic         tail_ok;
	logic         verdict_q [$];

	function automatic bit in_span(logic [20:0] cp, int unsigned lo, int unsigned hi);
		return cp >= lo && cp <= hi;
	endfunction

	// control, format and separator classes
	function automatic bit cp_banned(logic [20:0] cp);
		return in_span(cp, 'h0, 'h1F) || in_span(cp, 'h7F, 'h9F) ||
			in_span(cp, 'hAD, 'hAD) || in_span(cp, 'h600, 'h605) ||
			in_span(cp, 'h61C, 'h61C) || in_span(cp, 'h6DD, 'h6DD) ||
			in_span(cp, 'h70F, 'h70F) || in_span(cp, 'h8E2, 'h8E2) ||
			in_span(cp, 'h180E, 'h180E) || in_span(cp, 'h200B, 'h200F) ||
			in_span(cp, 'h202A, 'h202E) || in_span(cp, 'h2060, 'h2064) ||
			in_span(cp, 'h2066, 'h206F) || in_span(cp, 'hFEFF, 'hFEFF) ||
			in_span(cp, 'hFFF9, 'hFFFB) || in_span(cp, 'h110BD, 'h110BD) ||
			in_span(cp, 'h110CD, 'h110CD) || in_span(cp, 'h13430, 'h13438) ||
			in_span(cp, 'h1BCA0, 'h1BCA3) || in_span(cp, 'h1D173, 'h1D17A) ||
			in_span(cp, 'hE0001, 'hE0001) || in_span(cp, 'hE0020, 'hE007F) ||
			in_span(cp, 'h20, 'h20) || in_span(cp, 'hA0, 'hA0) ||
			in_span(cp, 'h1680, 'h1680) || in_span(cp, 'h2000, 'h200A) ||
			in_span(cp, 'h2028, 'h2029) || in_span(cp, 'h202F, 'h202F) ||
			in_span(cp, 'h205F, 'h205F) || in_span(cp, 'h3000, 'h3000);
	endfunction

	function automatic bit is_digit(logic [7:0] b);
		return b >= tiv_pkg::CH_0 && b <= tiv_pkg::CH_9;
	endfunction

	function automatic bit is_name_char(logic [7:0] b);
		return (b >= tiv_pkg::CH_LA && b <= tiv_pkg::CH_LZ) ||
			(b >= tiv_pkg::CH_UA && b <= tiv_pkg::CH_UZ) ||
			is_digit(b) || b == tiv_pkg::CH_HYPHEN;
	endfunction

	task automatic clear_parser();
		phase     = P_D;
		rejected  = 1'b0;
		cont_left = 2'd0;
		cp_acc    = '0;
		tail_ok   = 1'b0;
	endtask

	task automatic close_cp(input logic [20:0] cp);
		if (cp_banned(cp)) begin
			rejected = 1'b1;
		end else begin
			tail_ok = 1'b1;
		end
	endtask

	// continuation bytes contribute only their low six bits
	task automatic tail_byte(input logic [7:0] b);
		if (cont_left != 2'd0) begin
			cp_acc    = {cp_acc[14:0], b[5:0]};
			cont_left = cont_left - 2'd1;
			if (cont_left == 2'd0) begin
				close_cp(cp_acc);
			end
		end else if (b <= 8'h7F) begin
			close_cp({13'd0, b});
		end else if (b[7:5] == 3'b110) begin
			cp_acc    = {16'd0, b[4:0]};
			cont_left = 2'd1;
		end else if (b[7:4] == 4'b1110) begin
			cp_acc    = {17'd0, b[3:0]};
			cont_left = 2'd2;
		end else if (b[7:3] == 5'b11110) begin
			cp_acc    = {18'd0, b[2:0]};
			cont_left = 2'd3;
		end else begin
			close_cp('0);
		end
	endtask

	task automatic parse_byte(input logic [7:0] b, input logic lst);
		if (!rejected) begin
			case (phase)
				P_D: begin
					if (b == tiv_pkg::CH_D) phase = P_COLON1;
					else rejected = 1'b1;
				end
				P_COLON1: begin
					if (b == tiv_pkg::CH_COLON) phase = P_US1;
					else rejected = 1'b1;
				end
				P_US1: begin
					if (b == tiv_pkg::CH_US) phase = P_KIND;
					else rejected = 1'b1;
				end
				P_KIND: begin
					if (b == tiv_pkg::CH_I) phase = P_ICOLON;
					else if (b == tiv_pkg::CH_N) phase = P_NCOLON;
					else rejected = 1'b1;
				end
				P_ICOLON: begin
					if (b == tiv_pkg::CH_COLON) phase = P_IFIRST;
					else rejected = 1'b1;
				end
				P_IFIRST: begin
					if (b >= tiv_pkg::CH_1 && b <= tiv_pkg::CH_9) phase = P_IMORE;
					else rejected = 1'b1;
				end
				P_IMORE: begin
					if (b == tiv_pkg::CH_US) phase = P_TAIL;
					else if (!is_digit(b)) rejected = 1'b1;
				end
				P_NCOLON: begin
					if (b == tiv_pkg::CH_COLON) phase = P_NFIRST;
					else rejected = 1'b1;
				end
				P_NFIRST: begin
					if (is_name_char(b)) phase = P_NMORE;
					else rejected = 1'b1;
				end
				P_NMORE: begin
					if (b == tiv_pkg::CH_US) phase = P_TAIL;
					else if (!is_name_char(b)) rejected = 1'b1;
				end
				P_TAIL: tail_byte(b);
				default: rejected = 1'b1;
			endcase
		end
		if (lst) begin
			verdict_q.push_back(!rejected && phase == P_TAIL && cont_left == 2'd0 && tail_ok);
			clear_parser();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_parser();
			verdict_q.delete();
			fails            = 0;
			verdicts_pending = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (verdict_q.size() == 0) begin
					if (fails < 10)
						$display("%0t: unexpected verdict m_tdata=%h", $realtime, m_tdata);
					fails++;
				end else if (m_tdata !== {7'd0, verdict_q[0]}) begin
					if (fails < 10)
						$display("%0t: verdict mismatch expected m_tdata=%h actual m_tdata=%h",
							$realtime, {7'd0, verdict_q[0]}, m_tdata);
					fails++;
					void'(verdict_q.pop_front());
				end else begin
					void'(verdict_q.pop_front());
				end
			end
			if (s_tvalid && s_tready)
				parse_byte(s_tdata, s_tlast);
			verdicts_pending = verdict_q.size();
		end
	end

endmodule

[bench/tb_tagged_id_utf8_validator.sv]
// Testbench top for tagged_id_utf8_validator: clock, reset, byte stimulus and verdict.
// Streams directed and random tagged strings under varied idle and stall phases;
// depends on tiv_pkg and tiv_checker.
`timescale 1ns / 100ps

module tb_tagged_id_utf8_validator;

	logic       clk      = 1'b0;
	logic       arst_n   = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata  = 8'd0;   // [7:0] byte_req
	logic       s_tlast  = 1'b0;   // last
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;           // [0] match, [7:1] zero

	int idle_pct  = 0;
	int stall_pct = 0;
	int fails;
	int verdicts_pending;

	logic [7:0] str_q [$];

	// code points on and around the edges of the banned classes
	int unsigned notable_cp [52] = '{
		'h1F, 'h20, 'h21, 'h7E, 'h7F, 'h9F, 'hA0, 'hA1,
		'hAD, 'h600, 'h605, 'h606, 'h61C, 'h6DD, 'h70F, 'h8E2,
		'h180E, 'h1680, 'h2000, 'h200A, 'h200B, 'h200F, 'h2010, 'h2028,
		'h2029, 'h202A, 'h202E, 'h202F, 'h205F, 'h2060, 'h2064, 'h2065,
		'h2066, 'h206F, 'h3000, 'hFEFF, 'hFFF9, 'hFFFB, 'hFFFC, 'h110BD,
		'h110CD, 'h13430, 'h13438, 'h1BCA0, 'h1BCA3, 'h1D173, 'h1D17A, 'hE0001,
		'hE0020, 'hE007F, 'hE0080, 'h1FFFFF
	};

	always #5 clk = ~clk;

	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= stall_pct);

	tagged_id_utf8_validator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	tiv_checker checker_i (
		.clk              (clk),
		.arst_n           (arst_n),
		.s_tvalid         (s_tvalid),
		.s_tready         (s_tready),
		.s_tdata          (s_tdata),
		.s_tlast          (s_tlast),
		.m_tvalid         (m_tvalid),
		.m_tready         (m_tready),
		.m_tdata          (m_tdata),
		.fails            (fails),
		.verdicts_pending (verdicts_pending)
	);

	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// called at a falling edge, returns at the falling edge after the transaction
	task automatic push_byte(input logic [7:0] b, input logic lst);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= lst;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic send_string();
		for (int i = 0; i < str_q.size(); i++)
			push_byte(str_q[i], i == str_q.size() - 1);
		str_q.delete();
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			str_q.push_back(s[i]);
	endtask

	function automatic logic [7:0] corrupt(input logic [7:0] b, input int pct);
		return ($urandom_range(99) < pct) ? 8'($urandom) : b;
	endfunction

	function automatic logic [7:0] cont(input logic [5:0] bits);
		return {($urandom_range(9) == 0) ? 2'($urandom) : 2'b10, bits};
	endfunction

	task automatic add_cp(input logic [20:0] cp, input int len, input bit trunc);
		logic [7:0] enc [$];
		case (len)
			1: enc.push_back(cp[7:0]);
			2: enc = '{{3'b110, cp[10:6]}, cont(cp[5:0])};
			3: enc = '{{4'b1110, cp[15:12]}, cont(cp[11:6]), cont(cp[5:0])};
			default: enc = '{{5'b11110, cp[20:18]}, cont(cp[17:12]), cont(cp[11:6]),
				cont(cp[5:0])};
		endcase
		if (trunc && enc.size() > 1) begin
			repeat ($urandom_range(1, enc.size() - 1)) void'(enc.pop_back());
		end
		foreach (enc[i]) str_q.push_back(enc[i]);
	endtask

	task automatic gen_string();
		string       name_set;
		int          n_cp;
		int          cat;
		bit          trunc;
		logic [20:0] cp;
		name_set = "abmzAMZ0189-";
		if ($urandom_range(99) < 10) begin
			repeat ($urandom_range(1, 6)) str_q.push_back(8'($urandom));
			return;
		end
		str_q.push_back(corrupt(tiv_pkg::CH_D, 4));
		str_q.push_back(corrupt(tiv_pkg::CH_COLON, 4));
		str_q.push_back(corrupt(tiv_pkg::CH_US, 4));
		if ($urandom_range(1)) begin
			str_q.push_back(corrupt(tiv_pkg::CH_I, 3));
			str_q.push_back(corrupt(tiv_pkg::CH_COLON, 3));
			str_q.push_back(($urandom_range(99) < 90) ? 8'(tiv_pkg::CH_1 + $urandom_range(8))
				: corrupt(tiv_pkg::CH_0, 50));
			repeat ($urandom_range(0, 4))
				str_q.push_back(corrupt(8'(tiv_pkg::CH_0 + $urandom_range(9)), 3));
		end else begin
			str_q.push_back(corrupt(tiv_pkg::CH_N, 3));
			str_q.push_back(corrupt(tiv_pkg::CH_COLON, 3));
			repeat ($urandom_range(1, 5))
				str_q.push_back(corrupt(name_set[$urandom_range(name_set.len() - 1)], 4));
		end
		str_q.push_back(corrupt(tiv_pkg::CH_US, 3));
		n_cp = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 3);
		for (int k = 0; k < n_cp; k++) begin
			trunc = (k == n_cp - 1) && ($urandom_range(99) < 8);
			cat = $urandom_range(89);
			if (cat < 30) begin
				str_q.push_back(8'($urandom_range(8'h21, 8'h7E)));
			end else if (cat < 40) begin
				str_q.push_back(8'($urandom_range(8'h7F)));
			end else if (cat < 65) begin
				cp = 21'(notable_cp[$urandom_range($size(notable_cp) - 1)]);
				add_cp(cp, (cp < 'h80) ? 1 : (cp < 'h800) ? 2 : (cp < 'h10000) ? 3 : 4,
					trunc);
			end else if (cat < 80) begin
				add_cp(21'($urandom), $urandom_range(2, 4), trunc);
			end else begin
				str_q.push_back(8'($urandom_range(8'h80, 8'hFF)));
			end
		end
	endtask

	initial begin
		int sent;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		add_text("d:_i:9_~");
		send_string();
		add_text("x");
		send_string();
		add_text("d:_n:-_");
		str_q.push_back(8'hFF);
		send_string();
		add_text("d:_n:Z_");
		str_q.push_back(8'hE3);
		str_q.push_back(8'h80);
		send_string();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 65; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 65; end
				default: begin idle_pct = 7; stall_pct = 7; end
			endcase
			sent = 0;
			while (sent < 275) begin
				gen_string();
				sent += str_q.size();
				send_string();
			end
			s_tvalid <= 1'b0;
			while (verdicts_pending != 0) @(negedge clk);
			@(negedge clk);
		end

		stall_pct = 0;
		while (verdicts_pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (fails == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
